@@ rtl/plbt_pkg.sv @@
package plbt_pkg;

  // Levels held per side.
  localparam int LEVELS = 64;
  localparam int FILL_W = $clog2(LEVELS + 1);

  localparam int PRICE_W = 32;
  localparam int QTY_W   = 32;
  localparam int CNT_W   = 16;
  localparam int LVL_W   = 7;

  localparam logic OP_SET    = 1'b0;
  localparam logic OP_REMOVE = 1'b1;
  localparam logic SIDE_BID  = 1'b0;
  localparam logic SIDE_ASK  = 1'b1;

  // One book level as held by a cell.
  typedef struct packed {
    logic               valid;
    logic [PRICE_W-1:0] price;
    logic [QTY_W-1:0]   qty;
    logic [CNT_W-1:0]   cnt;
  } plbt_entry_t;

  // Request from the top level to one side.
  typedef struct packed {
    logic               cmp_en;
    logic               apply_en;
    logic               remove;
    logic [PRICE_W-1:0] key;
    logic [QTY_W-1:0]   qty;
    logic [CNT_W-1:0]   cnt;
  } plbt_req_t;

  // Broadcast control from a side to every cell of its row.
  typedef struct packed {
    logic               cmp_en;
    logic               ovr_en;
    logic               ins_en;
    logic               rem_en;
    logic               is_ask;
    logic [PRICE_W-1:0] key;
    logic [QTY_W-1:0]   qty;
    logic [CNT_W-1:0]   cnt;
  } plbt_cell_ctl_t;

  // Status of one side back to the top level.
  typedef struct packed {
    logic               best_valid;
    logic [PRICE_W-1:0] best_price;
    logic [FILL_W-1:0]  fill;
    logic               drop;
  } plbt_status_t;

endpackage

@@ rtl/price_level_book_table.sv @@
// Price level book table. Each side (bids highest first, asks lowest first)
// is a row of plbt_pkg::LEVELS cells, each holding one level's price, total
// quantity and order count, sorted so that the first cell holds the best
// price. A set request overwrites the level at its price or inserts it in
// sorted place, and a remove request deletes it; both happen by having every
// cell compare the key at once and then take its neighbor's contents. Each
// accepted request produces one result with the best bid, best ask (0 when a
// side is empty) and both level counts; dropped_full flags an insert into a
// full side, which leaves the book unchanged. A request passes through a
// compare step and an apply step of the cell rows, then waits in the done
// state until its result is loaded into the output register; a new request
// is taken only after that load, and a result that is not taken holds the
// next request in its final step until the output register frees.
module price_level_book_table (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_opcode,
  input  logic                           in_side,
  input  logic [plbt_pkg::PRICE_W-1:0]   in_price,
  input  logic [plbt_pkg::QTY_W-1:0]     in_total_qty,
  input  logic [plbt_pkg::CNT_W-1:0]     in_order_count,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [plbt_pkg::PRICE_W-1:0]   out_best_bid,
  output logic [plbt_pkg::PRICE_W-1:0]   out_best_ask,
  output logic [plbt_pkg::LVL_W-1:0]     out_bid_levels,
  output logic [plbt_pkg::LVL_W-1:0]     out_ask_levels,
  output logic                           out_dropped_full
);

  typedef enum logic [1:0] {S_IDLE, S_CMP, S_APPLY, S_DONE} state_t;

  state_t                          state_r;
  logic                            op_r;
  logic                            side_r;
  logic [plbt_pkg::PRICE_W-1:0]    price_r;
  logic [plbt_pkg::QTY_W-1:0]      qty_r;
  logic [plbt_pkg::CNT_W-1:0]      cnt_r;
  logic                            drop_r;
  logic                            out_valid_r;
  logic [plbt_pkg::PRICE_W-1:0]    bid_top_r;
  logic [plbt_pkg::PRICE_W-1:0]    ask_top_r;
  logic [plbt_pkg::LVL_W-1:0]      bid_levels_r;
  logic [plbt_pkg::LVL_W-1:0]      ask_levels_r;
  logic                            dropped_r;

  plbt_pkg::plbt_req_t             bid_req, ask_req;
  plbt_pkg::plbt_status_t          bid_stat, ask_stat;
  logic [plbt_pkg::FILL_W+plbt_pkg::LVL_W-1:0] bid_fill_ext, ask_fill_ext;
  logic                            load_out;

  // The request is broadcast to both rows; only the addressed side acts.
  always_comb begin
    bid_req.cmp_en   = (state_r == S_CMP)   && (side_r == plbt_pkg::SIDE_BID);
    bid_req.apply_en = (state_r == S_APPLY) && (side_r == plbt_pkg::SIDE_BID);
    bid_req.remove   = (op_r == plbt_pkg::OP_REMOVE);
    bid_req.key      = price_r;
    bid_req.qty      = qty_r;
    bid_req.cnt      = cnt_r;
    ask_req          = bid_req;
    ask_req.cmp_en   = (state_r == S_CMP)   && (side_r == plbt_pkg::SIDE_ASK);
    ask_req.apply_en = (state_r == S_APPLY) && (side_r == plbt_pkg::SIDE_ASK);
  end

  plbt_side u_bid (
    .clk    (clk),
    .rst_n  (rst_n),
    .is_ask (1'b0),
    .req    (bid_req),
    .status (bid_stat)
  );

  plbt_side u_ask (
    .clk    (clk),
    .rst_n  (rst_n),
    .is_ask (1'b1),
    .req    (ask_req),
    .status (ask_stat)
  );

  // Level counts pass unchanged to the seven-bit result fields, as fill is seven bits wide.
  assign bid_fill_ext = {{plbt_pkg::LVL_W{1'b0}}, bid_stat.fill};
  assign ask_fill_ext = {{plbt_pkg::LVL_W{1'b0}}, ask_stat.fill};

  assign in_ready = (state_r == S_IDLE);
  assign load_out = (state_r == S_DONE) && (!out_valid_r || out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      // A new result replaces a taken one in the same cycle.
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            op_r    <= in_opcode;
            side_r  <= in_side;
            price_r <= in_price;
            qty_r   <= in_total_qty;
            cnt_r   <= in_order_count;
            state_r <= S_CMP;
          end
        end
        S_CMP: begin
          state_r <= S_APPLY;
        end
        S_APPLY: begin
          drop_r  <= bid_stat.drop || ask_stat.drop;
          state_r <= S_DONE;
        end
        S_DONE: begin
          if (load_out) begin
            bid_top_r    <= bid_stat.best_valid ? bid_stat.best_price : '0;
            ask_top_r    <= ask_stat.best_valid ? ask_stat.best_price : '0;
            bid_levels_r <= bid_fill_ext[plbt_pkg::LVL_W-1:0];
            ask_levels_r <= ask_fill_ext[plbt_pkg::LVL_W-1:0];
            dropped_r    <= drop_r;
            state_r      <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid        = out_valid_r;
  assign out_best_bid     = bid_top_r;
  assign out_best_ask     = ask_top_r;
  assign out_bid_levels   = bid_levels_r;
  assign out_ask_levels   = ask_levels_r;
  assign out_dropped_full = dropped_r;

`ifndef SYNTHESIS
  // The head cell holds a level exactly when the side is not empty.
  a_bid_head: assert property (@(posedge clk) disable iff (!rst_n)
    bid_stat.best_valid == (bid_stat.fill != '0))
    else $error("bid head cell disagrees with bid fill count");

  a_ask_head: assert property (@(posedge clk) disable iff (!rst_n)
    ask_stat.best_valid == (ask_stat.fill != '0))
    else $error("ask head cell disagrees with ask fill count");

  // A dropped insert can only come from a full side.
  a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_APPLY) && (bid_stat.drop || ask_stat.drop) |->
      (bid_stat.fill == plbt_pkg::FILL_W'(plbt_pkg::LEVELS)) ||
      (ask_stat.fill == plbt_pkg::FILL_W'(plbt_pkg::LEVELS)))
    else $error("insert dropped while side not full");

  // Fill counts change only at the end of the apply cycle.
  a_fill_hold: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && (state_r != S_DONE) |->
      $stable(bid_stat.fill) && $stable(ask_stat.fill))
    else $error("fill count changed outside apply");
`endif

endmodule

@@ rtl/plbt_cell.sv @@
module plbt_cell (
  input  logic                     clk,
  input  logic                     rst_n,
  input  plbt_pkg::plbt_cell_ctl_t ctl,
  input  plbt_pkg::plbt_entry_t    prev_entry,
  input  logic                     prev_ahead,
  input  plbt_pkg::plbt_entry_t    next_entry,
  output plbt_pkg::plbt_entry_t    entry,
  output logic                     ahead,
  output logic                     match
);

  plbt_pkg::plbt_entry_t entry_r, entry_nxt;
  logic                  ahead_r, ahead_nxt;
  logic                  match_r, match_nxt;
  logic                  before_key;

  // A held level sorts ahead of the key when it is a better price.
  assign before_key = ctl.is_ask ? (entry_r.price < ctl.key) : (entry_r.price > ctl.key);

  always_comb begin
    entry_nxt = entry_r;
    ahead_nxt = ahead_r;
    match_nxt = match_r;
    if (ctl.cmp_en) begin
      ahead_nxt = entry_r.valid && before_key;
      match_nxt = entry_r.valid && (entry_r.price == ctl.key);
    end
    if (ctl.ovr_en && match_r) begin
      entry_nxt.qty = ctl.qty;
      entry_nxt.cnt = ctl.cnt;
    end
    if (ctl.ins_en && !ahead_r) begin
      if (prev_ahead) begin
        entry_nxt.valid = 1'b1;
        entry_nxt.price = ctl.key;
        entry_nxt.qty   = ctl.qty;
        entry_nxt.cnt   = ctl.cnt;
      end else begin
        entry_nxt = prev_entry;
      end
    end
    if (ctl.rem_en && !ahead_r) begin
      entry_nxt = next_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_r <= '0;
      ahead_r <= 1'b0;
      match_r <= 1'b0;
    end else begin
      entry_r <= entry_nxt;
      ahead_r <= ahead_nxt;
      match_r <= match_nxt;
    end
  end

  assign entry = entry_r;
  assign ahead = ahead_r;
  assign match = match_r;

endmodule

@@ rtl/plbt_side.sv @@
module plbt_side (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   is_ask,
  input  plbt_pkg::plbt_req_t    req,
  output plbt_pkg::plbt_status_t status
);

  plbt_pkg::plbt_entry_t          entries [plbt_pkg::LEVELS];
  logic [plbt_pkg::LEVELS-1:0]    ahead;
  logic [plbt_pkg::LEVELS-1:0]    match;
  plbt_pkg::plbt_cell_ctl_t       ctl;
  plbt_pkg::plbt_entry_t          empty_entry;
  logic [plbt_pkg::FILL_W-1:0]    fill_r, fill_nxt;
  logic                           match_any;
  logic                           full;

  assign empty_entry = '0;
  assign match_any   = |match;
  assign full        = (fill_r == plbt_pkg::FILL_W'(plbt_pkg::LEVELS));

  always_comb begin
    ctl.cmp_en = req.cmp_en;
    ctl.ovr_en = req.apply_en && !req.remove;
    ctl.ins_en = req.apply_en && !req.remove && !match_any && !full;
    ctl.rem_en = req.apply_en && req.remove && match_any;
    ctl.is_ask = is_ask;
    ctl.key    = req.key;
    ctl.qty    = req.qty;
    ctl.cnt    = req.cnt;
  end

  for (genvar i = 0; i < plbt_pkg::LEVELS; i++) begin : g_cell
    plbt_pkg::plbt_entry_t prev_e, next_e;
    logic                  prev_a;
    if (i == 0) begin : g_head
      assign prev_e = empty_entry;
      assign prev_a = 1'b1;
    end else begin : g_body
      assign prev_e = entries[i-1];
      assign prev_a = ahead[i-1];
    end
    if (i == plbt_pkg::LEVELS - 1) begin : g_tail
      assign next_e = empty_entry;
    end else begin : g_inner
      assign next_e = entries[i+1];
    end
    plbt_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctl        (ctl),
      .prev_entry (prev_e),
      .prev_ahead (prev_a),
      .next_entry (next_e),
      .entry      (entries[i]),
      .ahead      (ahead[i]),
      .match      (match[i])
    );
  end

  always_comb begin
    fill_nxt = fill_r;
    if (ctl.ins_en) begin
      fill_nxt = fill_r + 1'b1;
    end else if (ctl.rem_en) begin
      fill_nxt = fill_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else begin
      fill_r <= fill_nxt;
    end
  end

  always_comb begin
    status.best_valid = entries[0].valid;
    status.best_price = entries[0].price;
    status.fill       = fill_r;
    status.drop       = req.apply_en && !req.remove && !match_any && full;
  end

endmodule
